>>> hw/rtl/wgbs_pkg.sv
// Shared types and constants of the wrapped-grid bilinear sampler.
// Holds the bank geometry, fixed-point widths, item codes and the FSM type.
// Depends on nothing.
`timescale 1ns / 1ps

package wgbs_pkg;

    localparam int MAX_SIDE_LOG2 = 8;
    localparam int FRAC_BITS     = 8;
    localparam int HEIGHT_BITS   = 16;
    localparam int COORD_BITS    = 24;
    localparam int OUT_BITS      = 24;
    localparam int LOG2_W        = 4;

    // Four banks chosen by the parities of x and y, each holding a quarter of the grid.
    localparam int BANK_AW    = 2 * MAX_SIDE_LOG2 - 2;
    localparam int BANK_DEPTH = 1 << BANK_AW;
    localparam int NUM_BANKS  = 4;

    localparam int WEIGHT_W = FRAC_BITS + 2;
    localparam int PROD0_W  = HEIGHT_BITS + WEIGHT_W;
    localparam int PROD1_W  = PROD0_W + WEIGHT_W;
    localparam int SHIFT_W  = PROD1_W - FRAC_BITS;

    localparam logic [FRAC_BITS:0] ONE_FIX = (FRAC_BITS + 1)'(1 << FRAC_BITS);

    localparam logic signed [OUT_BITS-1:0] OUT_MAX = {1'b0, {(OUT_BITS - 1){1'b1}}};
    localparam logic signed [OUT_BITS-1:0] OUT_MIN = {1'b1, {(OUT_BITS - 1){1'b0}}};

    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_OFF_GRID = 1'b1;

    typedef struct packed {
        logic                          en;
        logic [BANK_AW-1:0]            addr;
        logic signed [HEIGHT_BITS-1:0] data;
    } t_bank_wr;

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_PROD0 = 7'b0000100,
        ST_SUM0  = 7'b0001000,
        ST_PROD1 = 7'b0010000,
        ST_DONE  = 7'b0100000,
        ST_SPARE = 7'b1000000
    } t_state;

endpackage

>>> hw/rtl/wgbs_bank.sv
// One height bank: a synchronous memory with one write and one registered read port.
// Depends on wgbs_pkg for the bank geometry and the write bundle.
`timescale 1ns / 1ps

module wgbs_bank (
    input  logic                                  i_clk,
    input  wgbs_pkg::t_bank_wr                    i_wr,
    input  logic                                  i_rd_en,
    input  logic [wgbs_pkg::BANK_AW-1:0]          i_rd_addr,
    output logic signed [wgbs_pkg::HEIGHT_BITS-1:0] o_rd_data
);

    logic signed [wgbs_pkg::HEIGHT_BITS-1:0] mem [wgbs_pkg::BANK_DEPTH];
    logic signed [wgbs_pkg::HEIGHT_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hw/rtl/wrapped_grid_bilinear_sampler.sv
// Top level of the wrapped-grid bilinear sampler: control, addressing and blend datapath.
// Depends on wgbs_pkg and instantiates four wgbs_bank memories.
`timescale 1ns / 1ps

// The block keeps a square grid of signed 16-bit heights whose side is 2^side_log2
// points, and it serves two kinds of item on its input channel. A write item stores
// a height at the integer part of its coordinates, or reports an off-grid status and
// leaves the grid alone. A sample item wraps its fixed-point coordinates around the
// grid and returns the bilinear blend of the four surrounding points.
// Both channels use valid and stall. The input is taken when i_valid is high and
// o_stall is low; a result is taken when o_valid is high and i_stall is low.
// The grid lives in four banks selected by the parities of x and y, so the four
// corners of a sample always fall into different banks and are read together.
// A sample is read from the banks at acceptance, then passes the multiply and add
// stages PROD0, SUM0 and PROD1, and its result enters the output register in DONE.
// A write goes from acceptance straight to DONE for its status. The block works on
// one item at a time: o_stall stays high until the item leaves DONE, so a new item
// is taken only once the item before it is through its stages.
// The output register parts the two sides: while a result waits under i_stall the
// block is back in idle and may accept the next item, which then holds in its last
// stage until the output register frees up.
// After reset the banks are cleared to zero by a pass over all their rows, one row of
// each bank per cycle, during which o_stall is high. Writes to side_log2 through
// i_cfg_we and i_cfg_data are taken at any time and reset returns it to 8.

module wrapped_grid_bilinear_sampler (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic [wgbs_pkg::LOG2_W-1:0]             i_cfg_data,
    input  logic                                    i_valid,
    output logic                                    o_stall,
    input  logic                                    i_mode,
    input  logic signed [wgbs_pkg::COORD_BITS-1:0]  i_coord_x,
    input  logic signed [wgbs_pkg::COORD_BITS-1:0]  i_coord_y,
    input  logic signed [15:0]                      i_write_height,
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic signed [wgbs_pkg::OUT_BITS-1:0]    o_sampled_height,
    output logic                                    o_status
);

    localparam int MS = wgbs_pkg::MAX_SIDE_LOG2;
    localparam int FB = wgbs_pkg::FRAC_BITS;
    localparam int HB = wgbs_pkg::HEIGHT_BITS;
    localparam int AW = wgbs_pkg::BANK_AW;
    localparam int WW = wgbs_pkg::WEIGHT_W;
    localparam int P0 = wgbs_pkg::PROD0_W;
    localparam int P1 = wgbs_pkg::PROD1_W;
    localparam int SW = wgbs_pkg::SHIFT_W;
    localparam int CB = wgbs_pkg::COORD_BITS;
    localparam int IW = CB - FB;

    // Control state.
    wgbs_pkg::t_state r_state, n_state;
    logic [AW-1:0]    r_clr_addr;
    logic [wgbs_pkg::LOG2_W-1:0] r_side_log2;
    logic             r_o_valid;

    // Item payload carried through the stages.
    logic             r_is_write;
    logic             r_res_status;
    logic             r_x0p, r_y0p;
    logic [FB-1:0]    r_fx, r_fy;
    logic signed [P0-1:0] r_p00, r_p01, r_p10, r_p11;
    logic signed [P0-1:0] r_near, r_far;
    logic signed [P1-1:0] r_q0, r_q1;
    logic signed [wgbs_pkg::OUT_BITS-1:0] r_o_height;
    logic             r_o_status;

    logic             accept;
    logic             out_free;
    logic [wgbs_pkg::LOG2_W-1:0] lg_eff;
    logic [MS:0]      side;
    logic [MS-1:0]    mask;
    logic             wr_ok;
    logic [MS-1:0]    ix, iy;
    logic [MS-1:0]    x0, x1, y0, y1;

    wgbs_pkg::t_bank_wr     bank_wr [wgbs_pkg::NUM_BANKS];
    logic [AW-1:0]          bank_raddr [wgbs_pkg::NUM_BANKS];
    logic signed [HB-1:0]   bank_rdata [wgbs_pkg::NUM_BANKS];

    assign accept   = i_valid && !o_stall;
    assign o_stall  = (r_state != wgbs_pkg::ST_IDLE);
    assign out_free = !r_o_valid || !i_stall;

    // Effective side: codes below one act as one and codes above the maximum as the maximum.
    always_comb begin
        if (r_side_log2 == '0) begin
            lg_eff = wgbs_pkg::LOG2_W'(1);
        end else if (r_side_log2 > wgbs_pkg::LOG2_W'(MS)) begin
            lg_eff = wgbs_pkg::LOG2_W'(MS);
        end else begin
            lg_eff = r_side_log2;
        end
    end

    assign side = (MS + 1)'(1) << lg_eff;
    assign mask = MS'(side - (MS + 1)'(1));

    // A write lands only when both integer parts are non-negative and below the side.
    assign wr_ok = !i_coord_x[CB-1] && !i_coord_y[CB-1]
                && (i_coord_x[CB-1:FB] < IW'(side))
                && (i_coord_y[CB-1:FB] < IW'(side));
    assign ix = i_coord_x[FB+MS-1:FB];
    assign iy = i_coord_y[FB+MS-1:FB];

    // Sample corners; the mask folds both the wrap of the coordinate and the far corner.
    assign x0 = i_coord_x[FB+MS-1:FB] & mask;
    assign y0 = i_coord_y[FB+MS-1:FB] & mask;
    assign x1 = (x0 + MS'(1)) & mask;
    assign y1 = (y0 + MS'(1)) & mask;

    // Bank b holds the points whose x parity is b[0] and whose y parity is b[1].
    always_comb begin
        for (int b = 0; b < wgbs_pkg::NUM_BANKS; b++) begin
            logic [MS-1:0] xs, ys;
            xs = (x0[0] == b[0]) ? x0 : x1;
            ys = (y0[0] == b[1]) ? y0 : y1;
            bank_raddr[b] = {ys[MS-1:1], xs[MS-1:1]};
            if (r_state == wgbs_pkg::ST_CLEAR) begin
                bank_wr[b].en   = 1'b1;
                bank_wr[b].addr = r_clr_addr;
                bank_wr[b].data = '0;
            end else begin
                bank_wr[b].en   = accept && (i_mode == wgbs_pkg::MODE_WRITE) && wr_ok
                               && (ix[0] == b[0]) && (iy[0] == b[1]);
                bank_wr[b].addr = {iy[MS-1:1], ix[MS-1:1]};
                bank_wr[b].data = HB'(i_write_height);
            end
        end
    end

    for (genvar g = 0; g < wgbs_pkg::NUM_BANKS; g++) begin : g_bank
        wgbs_bank u_bank (
            .i_clk     (i_clk),
            .i_wr      (bank_wr[g]),
            .i_rd_en   (accept),
            .i_rd_addr (bank_raddr[g]),
            .o_rd_data (bank_rdata[g])
        );
    end

    // First multiply stage: each corner times its y weight.
    logic signed [HB-1:0] v00, v01, v10, v11;
    logic signed [P0-1:0] e00, e01, e10, e11;
    logic signed [WW-1:0] wy0, wy1;
    always_comb begin
        v00 = bank_rdata[{r_y0p, r_x0p}];
        v01 = bank_rdata[{~r_y0p, r_x0p}];
        v10 = bank_rdata[{r_y0p, ~r_x0p}];
        v11 = bank_rdata[{~r_y0p, ~r_x0p}];
        e00 = P0'(v00);
        e01 = P0'(v01);
        e10 = P0'(v10);
        e11 = P0'(v11);
        wy0 = WW'(wgbs_pkg::ONE_FIX - {1'b0, r_fy});
        wy1 = WW'(r_fy);
    end

    // Second multiply stage: each column sum times its x weight.
    logic signed [P0-1:0] en, ef;
    logic signed [WW-1:0] wx0, wx1;
    always_comb begin
        en  = r_near;
        ef  = r_far;
        wx0 = WW'(wgbs_pkg::ONE_FIX - {1'b0, r_fx});
        wx1 = WW'(r_fx);
    end

    // Final sum, floor shift and saturation.
    logic signed [P1-1:0] total;
    logic signed [SW-1:0] shifted;
    logic signed [wgbs_pkg::OUT_BITS-1:0] blend;
    always_comb begin
        total   = r_q0 + r_q1;
        shifted = SW'(total >>> FB);
        if (shifted > SW'(wgbs_pkg::OUT_MAX)) begin
            blend = wgbs_pkg::OUT_MAX;
        end else if (shifted < SW'(wgbs_pkg::OUT_MIN)) begin
            blend = wgbs_pkg::OUT_MIN;
        end else begin
            blend = wgbs_pkg::OUT_BITS'(shifted);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wgbs_pkg::ST_CLEAR: begin
                if (r_clr_addr == {AW{1'b1}}) begin
                    n_state = wgbs_pkg::ST_IDLE;
                end
            end
            wgbs_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = (i_mode == wgbs_pkg::MODE_WRITE) ? wgbs_pkg::ST_DONE
                                                               : wgbs_pkg::ST_PROD0;
                end
            end
            wgbs_pkg::ST_PROD0: n_state = wgbs_pkg::ST_SUM0;
            wgbs_pkg::ST_SUM0:  n_state = wgbs_pkg::ST_PROD1;
            wgbs_pkg::ST_PROD1: n_state = wgbs_pkg::ST_DONE;
            wgbs_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = wgbs_pkg::ST_IDLE;
                end
            end
            default: n_state = wgbs_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wgbs_pkg::ST_CLEAR;
            r_clr_addr  <= '0;
            r_side_log2 <= wgbs_pkg::LOG2_W'(MS);
            r_o_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == wgbs_pkg::ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cfg_we) begin
                r_side_log2 <= i_cfg_data;
            end
            if (r_state == wgbs_pkg::ST_DONE && out_free) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_is_write   <= (i_mode == wgbs_pkg::MODE_WRITE);
            r_res_status <= (i_mode == wgbs_pkg::MODE_WRITE && !wr_ok)
                            ? wgbs_pkg::STATUS_OFF_GRID : wgbs_pkg::STATUS_OK;
            r_x0p        <= x0[0];
            r_y0p        <= y0[0];
            r_fx         <= i_coord_x[FB-1:0];
            r_fy         <= i_coord_y[FB-1:0];
        end
        if (r_state == wgbs_pkg::ST_PROD0) begin
            r_p00 <= e00 * wy0;
            r_p01 <= e01 * wy1;
            r_p10 <= e10 * wy0;
            r_p11 <= e11 * wy1;
        end
        if (r_state == wgbs_pkg::ST_SUM0) begin
            r_near <= r_p00 + r_p01;
            r_far  <= r_p10 + r_p11;
        end
        if (r_state == wgbs_pkg::ST_PROD1) begin
            r_q0 <= en * wx0;
            r_q1 <= ef * wx1;
        end
        if (r_state == wgbs_pkg::ST_DONE && out_free) begin
            r_o_height <= r_is_write ? '0 : blend;
            r_o_status <= r_res_status;
        end
    end

    assign o_valid          = r_o_valid;
    assign o_sampled_height = r_o_height;
    assign o_status         = r_o_status;

endmodule

>>> hw/rtl/wgbs_checker.sv
// Port-level checker for the wrapped-grid bilinear sampler, bound to the top level.
// Depends on wgbs_pkg for widths and codes.
`timescale 1ns / 1ps

module wgbs_checker (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   i_valid,
    input logic                                   o_stall,
    input logic                                   o_valid,
    input logic                                   i_stall,
    input logic signed [wgbs_pkg::OUT_BITS-1:0]   o_sampled_height,
    input logic                                   o_status
);

    // A result held under stall keeps its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_sampled_height) && $stable(o_status))
        else $error("stalled result changed");

    // An off-grid status only comes from a write, whose height is zero.
    a_offgrid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == wgbs_pkg::STATUS_OFF_GRID) |-> o_sampled_height == '0)
        else $error("off-grid result carries a height");

    // One item at a time: the input side is busy right after an acceptance.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second item taken while one is in flight");

    // A new result only appears while an item was being worked on.
    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result appeared without an item in flight");

endmodule

bind wrapped_grid_bilinear_sampler wgbs_checker u_wgbs_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_stall          (o_stall),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_sampled_height (o_sampled_height),
    .o_status         (o_status)
);

>>> test/wgbs_tb_pkg.sv
`timescale 1ns / 1ps
// Item types and the height-grid scoreboard used by the sampler testbench.
// Depends on wgbs_pkg for widths, item codes and status codes.

package wgbs_tb_pkg;

    import wgbs_pkg::*;

    localparam int GRID_DIM    = 1 << MAX_SIDE_LOG2;
    localparam int GRID_POINTS = GRID_DIM * GRID_DIM;
    localparam int FIX_ONE     = 1 << FRAC_BITS;

    typedef struct packed {
        logic                          mode;
        logic signed [COORD_BITS-1:0]  coord_x;
        logic signed [COORD_BITS-1:0]  coord_y;
        logic signed [15:0]            write_height;
    } grid_item_t;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] height;
        logic                       status;
    } grid_result_t;

    class height_grid_scoreboard;
        logic signed [HEIGHT_BITS-1:0] grid_heights [GRID_POINTS];
        logic [LOG2_W-1:0]             side_code;
        grid_result_t                  awaited_results [$];
        int                            mismatches;
        int                            results_seen;
        int                            samples_taken;
        int                            writes_stored;
        int                            writes_refused;

        function new();
            foreach (grid_heights[i]) grid_heights[i] = '0;
            side_code      = 4'd8;
            mismatches     = 0;
            results_seen   = 0;
            samples_taken  = 0;
            writes_stored  = 0;
            writes_refused = 0;
        endfunction

        function void set_side(logic [LOG2_W-1:0] code);
            side_code = code;
        endfunction

        // The register keeps any code, but the grid side is clamped to 2..2^MAX_SIDE_LOG2.
        function int side_in_use();
            int lg;
            lg = side_code;
            if (lg < 1) lg = 1;
            if (lg > MAX_SIDE_LOG2) lg = MAX_SIDE_LOG2;
            return 1 << lg;
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction

        // Works out the result of one accepted item and applies writes to the grid copy.
        function void predict_item(grid_item_t it);
            int           side;
            int           ix, iy, ux, uy, x0, y0, x1, y1;
            longint       fx, fy, v00, v01, v10, v11;
            longint       near_col, far_col, total, blend;
            grid_result_t want;
            side        = side_in_use();
            want.height = '0;
            want.status = STATUS_OK;
            if (it.mode == MODE_WRITE) begin
                ix = int'($signed(it.coord_x)) >>> FRAC_BITS;
                iy = int'($signed(it.coord_y)) >>> FRAC_BITS;
                if (ix < 0 || iy < 0 || ix >= side || iy >= side) begin
                    want.status = STATUS_OFF_GRID;
                    writes_refused++;
                end else begin
                    grid_heights[ix + iy * GRID_DIM] = it.write_height;
                    writes_stored++;
                end
            end else begin
                ux = int'($signed(it.coord_x)) & ((side << FRAC_BITS) - 1);
                uy = int'($signed(it.coord_y)) & ((side << FRAC_BITS) - 1);
                x0 = ux >> FRAC_BITS;
                y0 = uy >> FRAC_BITS;
                x1 = (x0 + 1) & (side - 1);
                y1 = (y0 + 1) & (side - 1);
                fx = ux & (FIX_ONE - 1);
                fy = uy & (FIX_ONE - 1);
                v00 = grid_heights[x0 + y0 * GRID_DIM];
                v01 = grid_heights[x0 + y1 * GRID_DIM];
                v10 = grid_heights[x1 + y0 * GRID_DIM];
                v11 = grid_heights[x1 + y1 * GRID_DIM];
                near_col = v00 * (FIX_ONE - fy) + v01 * fy;
                far_col  = v10 * (FIX_ONE - fy) + v11 * fy;
                total    = near_col * (FIX_ONE - fx) + far_col * fx;
                blend    = total >>> FRAC_BITS;
                if (blend > OUT_MAX) blend = OUT_MAX;
                if (blend < OUT_MIN) blend = OUT_MIN;
                want.height = blend[OUT_BITS-1:0];
                samples_taken++;
            end
            awaited_results.push_back(want);
        endfunction

        function void check_result(logic signed [OUT_BITS-1:0] got_height, logic got_status);
            grid_result_t want;
            results_seen++;
            if (awaited_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result %0d (height %0d, status %0d) with nothing awaited",
                             results_seen, got_height, got_status);
                return;
            end
            want = awaited_results.pop_front();
            if (got_height !== want.height || got_status !== want.status) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result %0d: height exp %0d got %0d, status exp %0d got %0d",
                             results_seen, want.height, got_height, want.status, got_status);
            end
        endfunction
    endclass

endpackage

>>> test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench of wrapped_grid_bilinear_sampler: stimulus, idling and verdict.
// Depends on wgbs_pkg and on the scoreboard in wgbs_tb_pkg.

module testbench;

    import wgbs_pkg::*;
    import wgbs_tb_pkg::*;

    localparam int RESET_CYCLES = 11;
    // A long receiver hold-off fills the output register and the last stage,
    // so the block has to stall its input while the sender keeps offering.
    localparam int HOLD_CYCLES  = 400;
    localparam int END_SETTLE   = 20;
    // The slowest correct run is the clearing pass plus every item with both sides
    // idling at their worst; this limit is several times that.
    localparam int CYCLE_LIMIT  = 500000;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [LOG2_W-1:0]             i_cfg_data;
    logic                          i_valid;
    logic                          o_stall;
    logic                          i_mode;
    logic signed [COORD_BITS-1:0]  i_coord_x;
    logic signed [COORD_BITS-1:0]  i_coord_y;
    logic signed [15:0]            i_write_height;
    logic                          o_valid;
    logic                          i_stall;
    logic signed [OUT_BITS-1:0]    o_sampled_height;
    logic                          o_status;

    height_grid_scoreboard sb;

    // Idling styles: 0 never waits, 1 draws a random wait before every item, 2 waits now and then.
    int          send_style  = 2;
    int          recv_style  = 1;
    bit          hold_request = 1'b0;
    int          holds_done   = 0;
    int          phases_run   = 0;
    int          items_sent   = 0;
    int          backpressure = 0;
    int unsigned cycle_count  = 0;

    wrapped_grid_bilinear_sampler dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_mode           (i_mode),
        .i_coord_x        (i_coord_x),
        .i_coord_y        (i_coord_y),
        .i_write_height   (i_write_height),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_sampled_height (o_sampled_height),
        .o_status         (o_status)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Run timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, sb.pending());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic int draw_gap(int style);
        case (style)
            0:       return 0;
            1:       return int'($urandom_range(0, 17));
            default: return ($urandom_range(0, 7) == 0) ? int'($urandom_range(1, 17)) : 0;
        endcase
    endfunction

    function automatic grid_item_t make_item(logic m, int x, int y, int h);
        grid_item_t it;
        it.mode         = m;
        it.coord_x      = COORD_BITS'(x);
        it.coord_y      = COORD_BITS'(y);
        it.write_height = 16'(h);
        return it;
    endfunction

    // A coordinate just inside or just outside the grid, in fixed point.
    function automatic int rim_coord(int side);
        case ($urandom_range(0, 3))
            0:       return -int'($urandom_range(1, 2 * FIX_ONE));
            1:       return side * FIX_ONE + int'($urandom_range(0, FIX_ONE - 1));
            2:       return (side - 1) * FIX_ONE + int'($urandom_range(0, FIX_ONE - 1));
            default: return int'($urandom_range(0, FIX_ONE - 1));
        endcase
    endfunction

    // Most writes land on the grid in use so that samples see real data; some
    // hug the rim, and a few carry fully random coordinates. Samples either use
    // the whole coordinate range or a band of a few grid widths around zero,
    // which exercises the toroidal wrap in both directions.
    function automatic grid_item_t random_item(int side);
        grid_item_t it;
        int         pick;
        it.mode = ($urandom_range(0, 9) < 4) ? MODE_WRITE : MODE_SAMPLE;
        pick    = $urandom_range(0, 9);
        if (pick == 0 || (it.mode == MODE_SAMPLE && pick < 3)) begin
            it.coord_x = COORD_BITS'($urandom);
            it.coord_y = COORD_BITS'($urandom);
        end else if (it.mode == MODE_WRITE && pick == 1) begin
            it.coord_x = COORD_BITS'(rim_coord(side));
            it.coord_y = COORD_BITS'(rim_coord(side));
        end else if (it.mode == MODE_WRITE) begin
            it.coord_x = COORD_BITS'((int'($urandom_range(0, side - 1)) << FRAC_BITS)
                                     | int'($urandom_range(0, FIX_ONE - 1)));
            it.coord_y = COORD_BITS'((int'($urandom_range(0, side - 1)) << FRAC_BITS)
                                     | int'($urandom_range(0, FIX_ONE - 1)));
        end else begin
            it.coord_x = COORD_BITS'(int'($urandom_range(0, 6 * side * FIX_ONE - 1))
                                     - 3 * side * FIX_ONE);
            it.coord_y = COORD_BITS'(int'($urandom_range(0, 6 * side * FIX_ONE - 1))
                                     - 3 * side * FIX_ONE);
        end
        case ($urandom_range(0, 7))
            0:       it.write_height = 16'sh7fff;
            1:       it.write_height = 16'sh8000;
            default: it.write_height = 16'($urandom);
        endcase
        return it;
    endfunction

    // Offers one item and returns on the falling edge after it was taken.
    // The task is entered on a falling edge; valid is only lowered when a gap
    // is drawn, so back-to-back items keep valid high without a glitch.
    task automatic send_item(input grid_item_t it);
        int gap;
        bit taken;
        gap = draw_gap(send_style);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_mode         <= it.mode;
        i_coord_x      <= it.coord_x;
        i_coord_y      <= it.coord_y;
        i_write_height <= it.write_height;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            if (!o_stall) begin
                taken = 1'b1;
                sb.predict_item(it);
                items_sent++;
            end else if (sb.pending() != 0) begin
                backpressure++;
            end
            @(negedge i_clk);
        end
    endtask

    // Stops offering and waits until every awaited result has been taken.
    // It always returns on a falling edge, so the caller may drive valid again at once.
    task automatic wait_for_results();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (sb.pending() != 0);
    endtask

    // The corners of the grid, off-grid writes on each side, wraps of
    // negative and extreme coordinates, and blends of all-max and all-min corners.
    task automatic directed_items();
        grid_item_t plan [$];
        plan.push_back(make_item(MODE_WRITE, 0, 0, 32767));
        plan.push_back(make_item(MODE_WRITE, 255 * 256 + 255, 255 * 256 + 1, -32768));
        plan.push_back(make_item(MODE_WRITE, 255 * 256, 0, 32767));
        plan.push_back(make_item(MODE_WRITE, 0, 255 * 256 + 128, -32768));
        plan.push_back(make_item(MODE_WRITE, -1, 0, 1));
        plan.push_back(make_item(MODE_WRITE, 3 * 256, 256 * 256, 1));
        plan.push_back(make_item(MODE_WRITE, 8388607, 5, 1));
        plan.push_back(make_item(MODE_WRITE, 7, -8388608, 1));
        plan.push_back(make_item(MODE_SAMPLE, 0, 0, 0));
        plan.push_back(make_item(MODE_SAMPLE, 255 * 256 + 128, 255 * 256 + 128, 0));
        plan.push_back(make_item(MODE_SAMPLE, -128, -128, 0));
        plan.push_back(make_item(MODE_SAMPLE, 8388607, 8388607, 0));
        plan.push_back(make_item(MODE_SAMPLE, -8388608, -8388608, 0));
        plan.push_back(make_item(MODE_WRITE, 256 + 1, 256, 32767));
        plan.push_back(make_item(MODE_WRITE, 512, 256, 32767));
        plan.push_back(make_item(MODE_WRITE, 256, 512, 32767));
        plan.push_back(make_item(MODE_WRITE, 512, 512, 32767));
        plan.push_back(make_item(MODE_SAMPLE, 256 + 255, 256 + 255, 0));
        plan.push_back(make_item(MODE_WRITE, 5 * 256, 5 * 256, -32768));
        plan.push_back(make_item(MODE_WRITE, 6 * 256, 5 * 256, -32768));
        plan.push_back(make_item(MODE_WRITE, 5 * 256, 6 * 256, -32768));
        plan.push_back(make_item(MODE_WRITE, 6 * 256, 6 * 256, -32768));
        plan.push_back(make_item(MODE_SAMPLE, 5 * 256 + 17, 5 * 256 + 200, 0));
        plan.push_back(make_item(MODE_SAMPLE, 128, 0, 0));
        plan.push_back(make_item(MODE_SAMPLE, 'h123456, -'h654321, 0));
        foreach (plan[k]) send_item(plan[k]);
    endtask

    // One phase: drain, set the grid side while the block is idle, then a
    // burst of random items under the chosen idling styles. A phase may ask
    // the receiver for a long hold-off, or pause halfway until all results are in.
    task automatic run_phase(input logic [LOG2_W-1:0] side_code, input int count,
                             input int s_style, input int r_style,
                             input bit with_hold, input bit with_pause);
        int n;
        wait_for_results();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= side_code;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_side(side_code);
        send_style = s_style;
        recv_style = r_style;
        phases_run++;
        if (with_hold) hold_request = 1'b1;
        for (n = 0; n < count; n++) begin
            if (with_pause && n == count / 2) wait_for_results();
            send_item(random_item(sb.side_in_use()));
        end
    endtask

    // Result side: before each result it honors a requested hold-off by counting
    // cycles on its own, draws a stall, then takes and checks one result.
    initial begin : result_sink
        int wait_n;
        bit got;
        @(negedge i_clk);
        forever begin
            if (hold_request) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_request = 1'b0;
                holds_done++;
            end
            wait_n = draw_gap(recv_style);
            if (wait_n > 0) begin
                i_stall <= 1'b1;
                repeat (wait_n) @(negedge i_clk);
            end
            i_stall <= 1'b0;
            got = 1'b0;
            while (!got) begin
                @(posedge i_clk);
                if (o_valid) begin
                    got = 1'b1;
                    sb.check_result(o_sampled_height, o_status);
                end
                @(negedge i_clk);
            end
        end
    end

    initial begin : stimulus
        bit clean;
        sb             = new();
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_data     = '0;
        i_valid        = 1'b0;
        i_mode         = MODE_WRITE;
        i_coord_x      = '0;
        i_coord_y      = '0;
        i_write_height = '0;
        i_stall        = 1'b0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // The directed items run at the reset side of 256 points; the block
        // first clears its banks, so the first item waits out that pass.
        directed_items();

        // Sides in range, both extremes, and codes that clamp (0 and above 8).
        run_phase(4'd1,  120, 1, 1, 1'b0, 1'b0);
        run_phase(4'd0,  110, 0, 0, 1'b0, 1'b0);
        run_phase(4'd15, 120, 1, 2, 1'b0, 1'b1);
        run_phase(4'd2,  120, 2, 1, 1'b0, 1'b0);
        run_phase(4'd3,  120, 0, 1, 1'b1, 1'b0);
        run_phase(4'd9,  120, 1, 0, 1'b0, 1'b0);
        run_phase(4'd4,  120, 1, 1, 1'b0, 1'b1);
        run_phase(4'd5,  120, 2, 2, 1'b0, 1'b0);
        run_phase(4'd8,  130, 1, 1, 1'b0, 1'b0);
        run_phase(4'd6,  110, 0, 2, 1'b0, 1'b0);
        run_phase(4'd7,  110, 1, 1, 1'b0, 1'b0);
        run_phase(4'd12, 110, 0, 0, 1'b1, 1'b0);

        wait_for_results();
        repeat (END_SETTLE) @(negedge i_clk);

        clean = (sb.mismatches == 0) && (sb.pending() == 0);
        $display("Covered %0d items across %0d grid sides: %0d samples, %0d writes stored, %0d off grid.",
                 items_sent, phases_run + 1, sb.samples_taken, sb.writes_stored,
                 sb.writes_refused);
        $display("Checked %0d results with %0d mismatches; %0d long hold-offs, %0d stalled offers.",
                 sb.results_seen, sb.mismatches, holds_done, backpressure);
        if (clean) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
